// ===== design/tcce_pkg.sv =====
// Shared types and constants for the text console character engine.
// No dependencies; every other design file but tcce_ram imports this package.
package tcce_pkg;

  localparam logic [7:0] RESET_COLOR = 8'h07;
  localparam logic [7:0] BLANK_CHAR  = 8'h20;
  localparam logic [15:0] RESET_CELL = {RESET_COLOR, BLANK_CHAR};

  localparam logic [7:0] CH_BELL      = 8'd7;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_READ,
    OP_BELL,
    OP_BACKSPACE,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_PRINT
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } op_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_COPY,
    BK_BLANK
  } back_state_t;

  typedef struct packed {
    logic clearing;
    logic scrolling;
  } back_status_t;

endpackage

// ===== design/tcce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tcce_fifo.sv =====
// Short operation queue between the front decoder and the back executor.
// Depends on tcce_pkg for the operation type and queue depth.
module tcce_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcce_pkg::op_t push_op,
  input  logic          pop,
  output tcce_pkg::op_t pop_op,
  output logic          full,
  output logic          empty
);
  import tcce_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  op_t          entries [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [QW:0]   count;

  assign full   = (count == (QW+1)'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign pop_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

// ===== design/tcce_front.sv =====
// Input side: accepts items and sorts them into operation kinds for the queue.
// Depends on tcce_pkg for character codes, operation and status types.
module tcce_front (
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   func,
  input  logic [7:0]             char_code,
  input  logic [10:0]            cell_index,
  input  logic                   queue_full,
  input  tcce_pkg::back_status_t status,
  output logic                   push,
  output tcce_pkg::op_t          push_op
);
  import tcce_pkg::*;

  // hold off input while the queue is full or the screen is being cleared after reset
  assign in_stall = queue_full || status.clearing;
  assign push     = in_valid && !in_stall;

  always_comb begin
    push_op.char_code  = char_code;
    push_op.cell_index = cell_index;
    if (func == FUNC_READ) begin
      push_op.kind = OP_READ;
    end else begin
      unique case (char_code)
        CH_BELL:      push_op.kind = OP_BELL;
        CH_BACKSPACE: push_op.kind = OP_BACKSPACE;
        CH_TAB:       push_op.kind = OP_TAB;
        CH_NEWLINE:   push_op.kind = OP_NEWLINE;
        CH_RETURN:    push_op.kind = OP_RETURN;
        default:      push_op.kind = OP_PRINT;
      endcase
    end
  end

endmodule

// ===== design/tcce_back.sv =====
// Back end: cursor logic, screen store, scroll and clear sequencing, result register.
// Depends on tcce_pkg and instantiates tcce_ram for the screen store.
module tcce_back #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25,
  parameter int TAB_STOP       = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   queue_empty,
  input  tcce_pkg::op_t          queue_op,
  output logic                   pop,
  input  logic [7:0]             color,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [4:0]             cursor_row,
  output logic [6:0]             cursor_column,
  output logic [10:0]            cursor_location,
  output logic [15:0]            cell_data,
  output tcce_pkg::back_status_t status
);
  import tcce_pkg::*;

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(SCREEN_ROWS);
  localparam int COL_W      = $clog2(SCREEN_COLUMNS);
  localparam int SUM_W      = $clog2(SCREEN_COLUMNS + TAB_STOP + 1);
  localparam int MOD_W      = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int LAST_MOD   = (SCREEN_COLUMNS - 1) % TAB_STOP;

  back_state_t       state, state_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [COL_W-1:0]  col, col_next;
  logic [MOD_W-1:0]  tmod, tmod_next;
  logic              pend, pend_next;
  logic [ADDR_W-1:0] pend_addr, pend_addr_next;
  logic              in_range, in_range_next;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [15:0]       wdata;
  logic [ADDR_W-1:0] raddr;
  logic [15:0]       rdata;

  logic              load;
  logic [15:0]       load_data;
  logic              lf;
  logic [SUM_W-1:0]  tab_sum;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] loc;
  logic [31:0]       row_ext, col_ext, loc_ext;

  tcce_ram #(
    .WIDTH(16),
    .DEPTH(CELL_COUNT)
  ) u_screen (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign status.clearing  = (state == BK_CLEAR);
  assign status.scrolling = (state == BK_COPY) || (state == BK_BLANK);

  assign cur_addr = ADDR_W'(row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col);
  assign tab_sum  = SUM_W'(col) + SUM_W'(TAB_STOP) - SUM_W'(tmod);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    row_next       = row;
    col_next       = col;
    tmod_next      = tmod;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    in_range_next  = in_range;
    we             = 1'b0;
    waddr          = cnt;
    wdata          = RESET_CELL;
    raddr          = cnt;
    pop            = 1'b0;
    load           = 1'b0;
    load_data      = 16'h0000;
    lf             = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        we = 1'b1;
        if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_next   = '0;
          state_next = BK_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      BK_IDLE: begin
        // take a new operation only once the result register is free
        if (!queue_empty && !out_valid) begin
          pop = 1'b1;
          unique case (queue_op.kind)
            OP_READ: begin
              raddr         = ADDR_W'({21'b0, queue_op.cell_index});
              in_range_next = ({21'b0, queue_op.cell_index} < 32'(CELL_COUNT));
              state_next    = BK_READ;
            end
            OP_BELL: begin
            end
            OP_BACKSPACE: begin
              if (col != '0) begin
                col_next  = col - 1'b1;
                tmod_next = (tmod == '0) ? MOD_W'(TAB_STOP - 1) : tmod - 1'b1;
              end else if (row != '0) begin
                col_next  = COL_W'(SCREEN_COLUMNS - 1);
                tmod_next = MOD_W'(LAST_MOD);
                row_next  = row - 1'b1;
              end
            end
            OP_NEWLINE: begin
              lf        = 1'b1;
              col_next  = '0;
              tmod_next = '0;
            end
            OP_RETURN: begin
              col_next  = '0;
              tmod_next = '0;
            end
            OP_TAB: begin
              tmod_next = '0;
              if (tab_sum >= SUM_W'(SCREEN_COLUMNS)) begin
                col_next = '0;
                lf       = 1'b1;
              end else begin
                col_next = COL_W'(tab_sum);
              end
            end
            OP_PRINT: begin
              we    = 1'b1;
              waddr = cur_addr;
              wdata = {color, queue_op.char_code};
              if (col == COL_W'(SCREEN_COLUMNS - 1)) begin
                col_next  = '0;
                tmod_next = '0;
                lf        = 1'b1;
              end else begin
                col_next  = col + 1'b1;
                tmod_next = (tmod == MOD_W'(TAB_STOP - 1)) ? '0 : tmod + 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (lf && (row >= ROW_W'(SCREEN_ROWS - 1))) begin
            // bottom line: scroll the store, the row stays put
            cnt_next   = ADDR_W'(SCREEN_COLUMNS);
            state_next = BK_COPY;
          end else begin
            if (lf) begin
              row_next = row + 1'b1;
            end
            if (queue_op.kind != OP_READ) begin
              load = 1'b1;
            end
          end
        end
      end
      BK_READ: begin
        load       = 1'b1;
        load_data  = in_range ? rdata : 16'h0000;
        state_next = BK_IDLE;
      end
      BK_COPY: begin
        // read one line down, write it back in the next cycle
        raddr          = cnt;
        pend_next      = 1'b1;
        pend_addr_next = cnt - ADDR_W'(SCREEN_COLUMNS);
        if (pend) begin
          we    = 1'b1;
          waddr = pend_addr;
          wdata = rdata;
        end
        if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_next   = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS);
          state_next = BK_BLANK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      BK_BLANK: begin
        we = 1'b1;
        if (pend) begin
          // drain the last copy write first
          waddr = pend_addr;
          wdata = rdata;
        end else begin
          wdata = {color, BLANK_CHAR};
          if (cnt == ADDR_W'(CELL_COUNT - 1)) begin
            cnt_next   = '0;
            load       = 1'b1;
            state_next = BK_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  assign loc     = ADDR_W'(row_next) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col_next);
  assign row_ext = 32'(row_next);
  assign col_ext = 32'(col_next);
  assign loc_ext = 32'(loc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      cnt       <= '0;
      row       <= '0;
      col       <= '0;
      tmod      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      row       <= row_next;
      col       <= col_next;
      tmod      <= tmod_next;
      pend      <= pend_next;
      out_valid <= (out_valid && out_stall) || load;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    in_range  <= in_range_next;
    if (load) begin
      cursor_row      <= row_ext[4:0];
      cursor_column   <= col_ext[6:0];
      cursor_location <= loc_ext[10:0];
      cell_data       <= load_data;
    end
  end

endmodule

// ===== design/text_console_character_engine_core.sv =====
// Text console character engine, top level: config register, front, queue, back.
// Depends on tcce_pkg, tcce_front, tcce_fifo and tcce_back.
//
// Usage:
//   Input channel (in_valid/in_stall): func selects put character or read
//   cell; char_code is the byte to put, cell_index the cell to read.
//   Output channel (out_valid/out_stall): one result per item with the cursor
//   row, column and location after the item, and cell_data for a read.
//   Config channel (cfg_valid/cfg_ready/text_color) sets the attribute byte
//   used for printed characters and scroll blanking; write it only when idle.
// Timing:
//   After reset the screen store is cleared to spaces in color 7, one cell a
//   cycle; in_stall is high during that.
//   A put result is loaded when the back end pops it; a read goes through BK_READ.
//   A put that scrolls copies the store one cell per cycle through the single
//   RAM port pair, then blanks the bottom row before its result is loaded.
//   The back end takes a new item only once the output register is free;
//   a two-entry queue keeps taking items while a result waits in the output
//   register.
//   A stalled receiver holds the result; the queue then fills and stalls input.
module text_console_character_engine_core #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25,
  parameter int TAB_STOP       = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_column,
  output logic [10:0] cursor_location,
  output logic [15:0] cell_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  text_color
);
  import tcce_pkg::*;

  logic         [7:0] color;
  logic               push;
  op_t                push_op;
  logic               pop;
  op_t                pop_op;
  logic               queue_full;
  logic               queue_empty;
  back_status_t       status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color <= RESET_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      color <= text_color;
    end
  end

  tcce_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .char_code (char_code),
    .cell_index(cell_index),
    .queue_full(queue_full),
    .status    (status),
    .push      (push),
    .push_op   (push_op)
  );

  tcce_fifo u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .pop    (pop),
    .pop_op (pop_op),
    .full   (queue_full),
    .empty  (queue_empty)
  );

  tcce_back #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS),
    .TAB_STOP      (TAB_STOP)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .queue_empty    (queue_empty),
    .queue_op       (pop_op),
    .pop            (pop),
    .color          (color),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cursor_row     (cursor_row),
    .cursor_column  (cursor_column),
    .cursor_location(cursor_location),
    .cell_data      (cell_data),
    .status         (status)
  );

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> in_stall)
    else $error("input accepted during screen clear");

  a_scroll_no_result: assert property (@(posedge clk) disable iff (rst)
    status.scrolling |-> !out_valid)
    else $error("result shown while a scroll is in progress");

  a_queue_bounds: assert property (@(posedge clk) disable iff (rst)
    !(push && queue_full) && !(pop && queue_empty))
    else $error("queue overflow or underflow");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((32'(cursor_column) < SCREEN_COLUMNS) && (32'(cursor_row) < SCREEN_ROWS)))
    else $error("cursor out of screen range");
`endif

endmodule

// ===== bench/tb_text_console_character_engine_core.sv =====
// Self-checking bench for the text console character engine core.
// Depends on tcce_pkg and text_console_character_engine_core; keeps a shadow
// screen and cursor that predict every report the directed items do not give.
module tb_text_console_character_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tcce_pkg::*;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int TAB   = 8;
  localparam int CELLS = COLS * ROWS;

  localparam logic [7:0] DIRECTED_COLOR = 8'hFF;
  localparam int PHASE_ITEMS    = 150;
  localparam int PHASE_COUNT    = 3;
  localparam int SETTLE_CYCLES  = CELLS + COLS + 40;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_AT        = 120;
  localparam int HOLD_CYCLES    = 400;
  localparam int STEADY_FROM    = 260;
  localparam int STEADY_TO      = 340;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [4:0]  row;
    logic [6:0]  column;
    logic [10:0] location;
    logic [15:0] data;
  } cursor_report_t;

  typedef struct {
    logic           f;
    logic [7:0]     code;
    logic [10:0]    index;
    bit             typed;
    cursor_report_t want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = FUNC_PUT;
  logic [7:0]  char_code = 8'h00;
  logic [10:0] cell_index = 11'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_column;
  logic [10:0] cursor_location;
  logic [15:0] cell_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  text_color = RESET_COLOR;

  // shadow of the block's state
  logic [15:0] screen_shadow [CELLS];
  int          shadow_row;
  int          shadow_col;
  logic [7:0]  shadow_color;

  cursor_report_t awaited_reports [$];
  script_row_t    script [$];

  int  error_count = 0;
  int  reported = 0;
  int  items_accepted = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  steady = 1'b0;

  text_console_character_engine_core #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS(ROWS),
    .TAB_STOP(TAB)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .char_code(char_code),
    .cell_index(cell_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cursor_row(cursor_row),
    .cursor_column(cursor_column),
    .cursor_location(cursor_location),
    .cell_data(cell_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .text_color(text_color)
  );

  always #5 clk = ~clk;

  // Move down one row, or scroll and blank the bottom row on the last one.
  function automatic void advance_line();
    int k;
    if (shadow_row >= ROWS - 1) begin
      for (k = 0; k < CELLS - COLS; k++) screen_shadow[k] = screen_shadow[k + COLS];
      for (k = CELLS - COLS; k < CELLS; k++) screen_shadow[k] = {shadow_color, BLANK_CHAR};
    end else begin
      shadow_row++;
    end
  endfunction

  function automatic cursor_report_t console_predict(input logic f, input logic [7:0] code,
                                                     input logic [10:0] index);
    cursor_report_t rep;
    int             pos;
    rep.data = 16'h0000;
    if (f == FUNC_READ) begin
      if (int'(index) < CELLS) rep.data = screen_shadow[index];
    end else begin
      case (code)
        CH_BELL: begin
        end
        CH_BACKSPACE: begin
          if (shadow_col > 0) begin
            shadow_col--;
          end else if (shadow_row > 0) begin
            shadow_col = COLS - 1;
            shadow_row--;
          end
        end
        CH_NEWLINE: begin
          advance_line();
          shadow_col = 0;
        end
        CH_RETURN: begin
          shadow_col = 0;
        end
        CH_TAB: begin
          do shadow_col++; while ((shadow_col % TAB) != 0 && shadow_col != COLS);
          if (shadow_col == COLS) begin
            shadow_col = 0;
            advance_line();
          end
        end
        default: begin
          pos = shadow_row * COLS + shadow_col;
          if (pos < CELLS) screen_shadow[pos] = {shadow_color, code};
          shadow_col++;
          if (shadow_col == COLS) begin
            shadow_col = 0;
            advance_line();
          end
        end
      endcase
    end
    pos = shadow_row * COLS + shadow_col;
    rep.row = shadow_row[4:0];
    rep.column = shadow_col[6:0];
    rep.location = pos[10:0];
    return rep;
  endfunction

  task automatic add_row(input logic f, input logic [7:0] code, input logic [10:0] index,
                         input bit typed, input cursor_report_t want);
    script_row_t r;
    r.f = f;
    r.code = code;
    r.index = index;
    r.typed = typed;
    r.want = want;
    script.push_back(r);
  endtask

  // Offer one transaction, hold it until accepted, then record what it must report.
  task automatic issue_console_item(input logic f, input logic [7:0] code,
                                    input logic [10:0] index, input bit typed,
                                    input cursor_report_t want);
    cursor_report_t rep;
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    char_code <= code;
    cell_index <= index;
    do @(posedge clk); while (in_stall);
    rep = console_predict(f, code, index);
    awaited_reports.push_back(typed ? want : rep);
    items_accepted++;
    steady = (items_accepted >= STEADY_FROM && items_accepted < STEADY_TO);
  endtask

  task automatic write_text_color(input logic [7:0] value);
    cfg_valid <= 1'b1;
    text_color <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_color = value;
  endtask

  // Let every report drain and any trailing scroll finish before a register write.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls, one long hold-off, and a steady stretch.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_accepted >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 20);
    end
  end

  always @(posedge clk) begin
    cursor_report_t got;
    cursor_report_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {cursor_row, cursor_column, cursor_location, cell_data};
      if (awaited_reports.size() == 0) begin
        error_count++;
        if (reported < REPORT_LIMIT)
          $display("unexpected report: row %0d col %0d loc %0d data %h",
                   got.row, got.column, got.location, got.data);
        reported++;
      end else begin
        want = awaited_reports.pop_front();
        if (got !== want) begin
          error_count++;
          if (reported < REPORT_LIMIT)
            $display("mismatch: row %0d/%0d col %0d/%0d loc %0d/%0d data %h/%h (exp/act)",
                     want.row, got.row, want.column, got.column,
                     want.location, got.location, want.data, got.data);
          reported++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_text_console_character_engine_core: errors");
      $finish;
    end
  end

  initial begin
    int          n;
    int          p;
    int          sel;
    int          near;
    logic        f;
    logic [7:0]  code;
    logic [10:0] index;
    logic [7:0]  phase_color [PHASE_COUNT];

    for (n = 0; n < CELLS; n++) screen_shadow[n] = RESET_CELL;
    shadow_row = 0;
    shadow_col = 0;
    shadow_color = RESET_COLOR;

    // reset contents, out-of-range reads, cursor edges, tab wrap
    add_row(FUNC_READ, 8'h00, 11'd0, 1'b1, {5'd0, 7'd0, 11'd0, RESET_CELL});
    add_row(FUNC_READ, 8'h00, 11'd1999, 1'b1, {5'd0, 7'd0, 11'd0, RESET_CELL});
    add_row(FUNC_READ, 8'hFF, 11'd2047, 1'b1, {5'd0, 7'd0, 11'd0, 16'h0000});
    add_row(FUNC_READ, 8'h00, 11'd2000, 1'b1, {5'd0, 7'd0, 11'd0, 16'h0000});
    add_row(FUNC_PUT, CH_BELL, 11'd0, 1'b1, {5'd0, 7'd0, 11'd0, 16'h0000});
    add_row(FUNC_PUT, CH_BACKSPACE, 11'd0, 1'b1, {5'd0, 7'd0, 11'd0, 16'h0000});
    add_row(FUNC_PUT, 8'h41, 11'd0, 1'b1, {5'd0, 7'd1, 11'd1, 16'h0000});
    add_row(FUNC_READ, 8'h00, 11'd0, 1'b1, {5'd0, 7'd1, 11'd1, DIRECTED_COLOR, 8'h41});
    add_row(FUNC_PUT, 8'hFF, 11'd0, 1'b1, {5'd0, 7'd2, 11'd2, 16'h0000});
    add_row(FUNC_PUT, 8'h00, 11'd0, 1'b1, {5'd0, 7'd3, 11'd3, 16'h0000});
    add_row(FUNC_READ, 8'h00, 11'd1, 1'b1, {5'd0, 7'd3, 11'd3, DIRECTED_COLOR, 8'hFF});
    add_row(FUNC_READ, 8'h00, 11'd2, 1'b1, {5'd0, 7'd3, 11'd3, DIRECTED_COLOR, 8'h00});
    add_row(FUNC_PUT, CH_TAB, 11'd0, 1'b1, {5'd0, 7'd8, 11'd8, 16'h0000});
    add_row(FUNC_PUT, CH_TAB, 11'd0, 1'b1, {5'd0, 7'd16, 11'd16, 16'h0000});
    add_row(FUNC_PUT, CH_BACKSPACE, 11'd0, 1'b0, '0);
    add_row(FUNC_PUT, CH_RETURN, 11'd0, 1'b0, '0);
    add_row(FUNC_PUT, CH_BACKSPACE, 11'd0, 1'b0, '0);
    add_row(FUNC_PUT, CH_NEWLINE, 11'd0, 1'b0, '0);
    add_row(FUNC_PUT, CH_BACKSPACE, 11'd0, 1'b0, '0);
    add_row(FUNC_PUT, 8'h5A, 11'd0, 1'b0, '0);
    add_row(FUNC_READ, 8'h00, 11'd79, 1'b0, '0);
    add_row(FUNC_PUT, CH_BACKSPACE, 11'd0, 1'b0, '0);
    add_row(FUNC_PUT, CH_TAB, 11'd0, 1'b0, '0);
    add_row(FUNC_READ, 8'hFF, 11'd80, 1'b0, '0);
    add_row(FUNC_PUT, 8'h80, 11'h7FF, 1'b0, '0);

    phase_color[0] = 8'h00;
    phase_color[1] = 8'($urandom_range(1, 254));
    phase_color[2] = 8'hFF;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_text_color(DIRECTED_COLOR);
    foreach (script[i])
      issue_console_item(script[i].f, script[i].code, script[i].index,
                         script[i].typed, script[i].want);

    for (p = 0; p < PHASE_COUNT; p++) begin
      settle();
      write_text_color(phase_color[p]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 28) begin
          f = FUNC_READ;
          code = 8'($urandom_range(0, 255));
          sel = $urandom_range(0, 99);
          if (sel < 55) begin
            // read around the cursor so fresh writes and scroll blanks get checked
            near = shadow_row * COLS - 2 * COLS + $urandom_range(0, 3 * COLS);
            if (near < 0) near = 0;
            if (near > CELLS - 1) near = CELLS - 1;
            index = near[10:0];
          end else if (sel < 90) begin
            index = 11'($urandom_range(0, CELLS - 1));
          end else begin
            index = 11'($urandom_range(CELLS, 2047));
          end
        end else begin
          f = FUNC_PUT;
          index = 11'($urandom_range(0, 2047));
          sel = $urandom_range(0, 99);
          if (sel < 12) code = CH_NEWLINE;
          else if (sel < 18) code = CH_TAB;
          else if (sel < 24) code = CH_BACKSPACE;
          else if (sel < 28) code = CH_RETURN;
          else if (sel < 31) code = CH_BELL;
          else code = 8'($urandom_range(0, 255));
        end
        issue_console_item(f, code, index, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_reports.size() != 0) error_count++;

    if (error_count == 0)
      $display("tb_text_console_character_engine_core: clean");
    else
      $display("tb_text_console_character_engine_core: errors");
    $finish;
  end

endmodule

// ===== text_console_character_engine_core.f =====
design/tcce_pkg.sv
design/tcce_ram.sv
design/tcce_fifo.sv
design/tcce_front.sv
design/tcce_back.sv
design/text_console_character_engine_core.sv
bench/tb_text_console_character_engine_core.sv
